// ===== hdl/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cycle controller package
// Shared types, register map and field widths of the battery cycle controller.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam int REQ_W  = 2;
	localparam int VOLT_W = 14;
	localparam int CURR_W = 16;
	localparam int TEMP_W = 12;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 8;

	localparam int CHG_END_W = 15;
	localparam int CNT_W     = 8;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_CHARGE    = 2'd1,
		ST_DISCHARGE = 2'd2
	} state_t;

	typedef enum logic [1:0] {
		PRE_NONE      = 2'd0,
		PRE_ZERO      = 2'd1,
		PRE_CHARGE    = 2'd2,
		PRE_DISCHARGE = 2'd3
	} preset_t;

	typedef enum logic [1:0] {
		REQ_NONE      = 2'd0,
		REQ_IDLE      = 2'd1,
		REQ_CHARGE    = 2'd2,
		REQ_DISCHARGE = 2'd3
	} request_t;

	typedef enum logic [2:0] {
		REG_CHARGE_END_MA       = 3'd0,
		REG_DISCHARGE_CUTOFF_MV = 3'd1,
		REG_AUTO_CYCLE          = 3'd2,
		REG_MAX_TEMP_DC         = 3'd3,
		REG_NO_BATTERY_MV       = 3'd4,
		REG_DEAD_TIME_TICKS     = 3'd5,
		REG_DEBOUNCE_LIMIT      = 3'd6
	} reg_idx_t;

	localparam logic [CHG_END_W-1:0] RST_CHARGE_END_MA       = 15'd100;
	localparam logic [VOLT_W-1:0]    RST_DISCHARGE_CUTOFF_MV = 14'd3000;
	localparam logic                 RST_AUTO_CYCLE          = 1'b0;
	localparam logic [TEMP_W-1:0]    RST_MAX_TEMP_DC         = 12'd500;
	localparam logic [VOLT_W-1:0]    RST_NO_BATTERY_MV       = 14'd2000;
	localparam logic [CNT_W-1:0]     RST_DEAD_TIME_TICKS     = 8'd10;
	localparam logic [CNT_W-1:0]     RST_DEBOUNCE_LIMIT      = 8'd3;

	function automatic preset_t preset_for(input state_t s);
		preset_t p;
		case (s)
			ST_CHARGE:    p = PRE_CHARGE;
			ST_DISCHARGE: p = PRE_DISCHARGE;
			default:      p = PRE_ZERO;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/battery_cycle_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cycle controller core
// Per-tick supervisor of a battery test cycler: picks idle, charge or
// discharge, drives both relays with a dead time on swaps and selects the
// current filter preset.
//
// Channel   Direction  Contents
// s_t*      in         one control tick: request, voltage, current, temperature
// m_t*      out        one result per tick: relays, state, preset, dead time flag
// APB       in/out     seven configuration registers at byte address 4*index
//
// A tick is taken into an input register, evaluated combinationally against the
// controller state and written to the output register, so a result passes the
// input and output registers in turn. A new tick can be taken every cycle
// unless both registers are full. A stalled output holds its result; the input
// side keeps accepting until both the input and output registers are full.
// Reset clears the controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_cycle_controller_core
	import bcc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// user_request[1:0], voltage_mv[15:2], current_ma[31:16], temp_dc[43:32]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// chg_relay[0], dis_relay[1], reported_state[3:2],
	// preset_kind[5:4], in_dead_time[6]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic [CHG_END_W-1:0] charge_end_ma_q;
	logic [VOLT_W-1:0]    discharge_cutoff_mv_q;
	logic                 auto_cycle_q;
	logic [TEMP_W-1:0]    max_temp_dc_q;
	logic [VOLT_W-1:0]    no_battery_mv_q;
	logic [CNT_W-1:0]     dead_time_ticks_q;
	logic [CNT_W-1:0]     debounce_limit_q;

	logic                 valid_s1;
	logic [REQ_W-1:0]     req_s1;
	logic [VOLT_W-1:0]    volt_s1;
	logic [CURR_W-1:0]    curr_s1;
	logic [TEMP_W-1:0]    temp_s1;

	logic                 valid_s2;
	logic [OUT_TDATA_W-1:0] data_s2;

	state_t               applied_q;
	state_t               target_q;
	logic [CNT_W-1:0]     pause_q;
	logic [CNT_W-1:0]     qualify_q;
	logic                 chg_relay_q;
	logic                 dis_relay_q;

	state_t               applied_n;
	state_t               target_n;
	logic [CNT_W-1:0]     pause_n;
	logic [CNT_W-1:0]     qualify_n;
	logic                 chg_relay_n;
	logic                 dis_relay_n;
	state_t               report_n;
	preset_t              preset_n;

	state_t               cmd;
	logic [CURR_W:0]      cur_ext;
	logic [CURR_W:0]      mag;
	logic                 fire;
	logic                 adv;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_end_ma_q       <= RST_CHARGE_END_MA;
			discharge_cutoff_mv_q <= RST_DISCHARGE_CUTOFF_MV;
			auto_cycle_q          <= RST_AUTO_CYCLE;
			max_temp_dc_q         <= RST_MAX_TEMP_DC;
			no_battery_mv_q       <= RST_NO_BATTERY_MV;
			dead_time_ticks_q     <= RST_DEAD_TIME_TICKS;
			debounce_limit_q      <= RST_DEBOUNCE_LIMIT;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_CHARGE_END_MA:       charge_end_ma_q       <= pwdata[CHG_END_W-1:0];
				REG_DISCHARGE_CUTOFF_MV: discharge_cutoff_mv_q <= pwdata[VOLT_W-1:0];
				REG_AUTO_CYCLE:          auto_cycle_q          <= pwdata[0];
				REG_MAX_TEMP_DC:         max_temp_dc_q         <= pwdata[TEMP_W-1:0];
				REG_NO_BATTERY_MV:       no_battery_mv_q       <= pwdata[VOLT_W-1:0];
				REG_DEAD_TIME_TICKS:     dead_time_ticks_q     <= pwdata[CNT_W-1:0];
				REG_DEBOUNCE_LIMIT:      debounce_limit_q      <= pwdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_CHARGE_END_MA:       prdata = CFG_DATA_W'(charge_end_ma_q);
			REG_DISCHARGE_CUTOFF_MV: prdata = CFG_DATA_W'(discharge_cutoff_mv_q);
			REG_AUTO_CYCLE:          prdata = CFG_DATA_W'(auto_cycle_q);
			REG_MAX_TEMP_DC:         prdata = CFG_DATA_W'($signed(max_temp_dc_q));
			REG_NO_BATTERY_MV:       prdata = CFG_DATA_W'(no_battery_mv_q);
			REG_DEAD_TIME_TICKS:     prdata = CFG_DATA_W'(dead_time_ticks_q);
			REG_DEBOUNCE_LIMIT:      prdata = CFG_DATA_W'(debounce_limit_q);
			default:                 prdata = '0;
		endcase
	end

	assign adv      = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tdata[1:0];
			volt_s1 <= s_tdata[15:2];
			curr_s1 <= s_tdata[31:16];
			temp_s1 <= s_tdata[43:32];
		end
	end

	always_comb begin
		applied_n   = applied_q;
		target_n    = target_q;
		pause_n     = pause_q;
		qualify_n   = qualify_q;
		chg_relay_n = chg_relay_q;
		dis_relay_n = dis_relay_q;
		report_n    = applied_q;
		preset_n    = PRE_NONE;
		cmd         = applied_q;
		cur_ext     = {curr_s1[CURR_W-1], curr_s1};
		mag         = curr_s1[CURR_W-1] ? ((CURR_W+1)'(0) - cur_ext) : cur_ext;
		fire        = qualify_q >= debounce_limit_q;

		if (pause_q != '0) begin
			pause_n     = pause_q - CNT_W'(1);
			chg_relay_n = 1'b0;
			dis_relay_n = 1'b0;
			report_n    = ST_IDLE;
			preset_n    = PRE_ZERO;
			if (pause_n == '0) begin
				applied_n = target_q;
				report_n  = target_q;
				preset_n  = preset_for(target_q);
			end
		end else begin
			case (request_t'(req_s1))
				REQ_IDLE:      cmd = ST_IDLE;
				REQ_CHARGE:    cmd = ST_CHARGE;
				REQ_DISCHARGE: cmd = ST_DISCHARGE;
				default:       cmd = applied_q;
			endcase

			// Supervision of the limits; the end-of-charge current and the discharge cutoff are debounced.
			case (cmd)
				ST_CHARGE: begin
					if (mag < (CURR_W+1)'(charge_end_ma_q)) begin
						qualify_n = fire ? '0 : qualify_q + CNT_W'(1);
						if (fire) begin
							cmd = ST_DISCHARGE;
						end
					end else if ($signed(temp_s1) > $signed(max_temp_dc_q)) begin
						qualify_n = '0;
						cmd       = ST_IDLE;
					end else if (volt_s1 < no_battery_mv_q) begin
						qualify_n = '0;
						cmd       = ST_IDLE;
					end else begin
						qualify_n = '0;
					end
				end
				ST_DISCHARGE: begin
					if (volt_s1 < discharge_cutoff_mv_q) begin
						qualify_n = fire ? '0 : qualify_q + CNT_W'(1);
						if (fire) begin
							cmd = auto_cycle_q ? ST_CHARGE : ST_IDLE;
						end
					end else if ($signed(temp_s1) > $signed(max_temp_dc_q)) begin
						qualify_n = '0;
						cmd       = ST_IDLE;
					end else begin
						qualify_n = '0;
					end
				end
				default: begin
				end
			endcase

			report_n = cmd;
			if ((applied_q == ST_CHARGE && cmd == ST_DISCHARGE) ||
				(applied_q == ST_DISCHARGE && cmd == ST_CHARGE)) begin
				// A direct swap opens a dead time; the relays keep their drive for now.
				target_n = cmd;
				pause_n  = (dead_time_ticks_q == '0) ? CNT_W'(1) : dead_time_ticks_q;
			end else begin
				if (cmd != applied_q) begin
					preset_n = preset_for(cmd);
				end
				applied_n   = cmd;
				chg_relay_n = (cmd == ST_CHARGE);
				dis_relay_n = (cmd == ST_DISCHARGE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q   <= ST_IDLE;
			target_q    <= ST_IDLE;
			pause_q     <= '0;
			qualify_q   <= '0;
			chg_relay_q <= 1'b0;
			dis_relay_q <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (adv) begin
				applied_q   <= applied_n;
				target_q    <= target_n;
				pause_q     <= pause_n;
				qualify_q   <= qualify_n;
				chg_relay_q <= chg_relay_n;
				dis_relay_q <= dis_relay_n;
				valid_s2    <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {1'b0, (pause_n != '0), preset_n, report_n, dis_relay_n, chg_relay_n};
		end
	end

`ifndef SYNTHESIS
	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(chg_relay_q && dis_relay_q))
		else $error("Both relays are closed at the same time.");

	a_relay_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(chg_relay_q |-> applied_q == ST_CHARGE) and (dis_relay_q |-> applied_q == ST_DISCHARGE))
		else $error("A relay is closed for a state that is not applied.");

	a_pause_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pause_q != '0 |=> pause_q == $past(pause_q) - CNT_W'(1))
		else $error("The dead-time counter did not count down on a tick.");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("The input side stalled while a register was free.");
`endif

endmodule

// ===== sim/battery_cycle_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cycle controller core testbench
// Drives control ticks into the stream input and checks every result on the
// stream output against a cycle-free model of the controller kept in the bench
// or, for typed rows, against the table. A short table of directed ticks covers
// reset behavior, field extremes, the charge/discharge swap and its dead time.
// Random phases follow, each after reprogramming all registers over APB while
// the core is drained. Both stream sides stall at random, except in one phase without stalls.
// ----------------------------------------------------------------------------
module battery_cycle_controller_core_tb;
	import bcc_pkg::*;

	localparam int CYC_LIMIT    = 300000;
	localparam int PHASES       = 8;
	localparam int PHASE_TICKS  = 175;
	localparam int DIR_ROWS     = 25;

	typedef struct packed {
		logic    dead_time;
		preset_t preset;
		state_t  state;
		logic    dis_relay;
		logic    chg_relay;
	} tick_res_t;

	typedef struct packed {
		request_t          req;
		logic [VOLT_W-1:0] volt;
		logic [CURR_W-1:0] cur;
		logic [TEMP_W-1:0] temp;
		bit                typed;
		tick_res_t         res;
	} dir_row_t;

	localparam tick_res_t NO_RES   = '0;
	localparam tick_res_t DEAD_RES = '{1'b1, PRE_ZERO, ST_IDLE, 1'b0, 1'b0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr = '0;
	logic [CFG_DATA_W-1:0]  pwdata = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	battery_cycle_controller_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Controller model state and its copy of the registers.
	state_t           cmd_st = ST_IDLE;
	state_t           appl_st = ST_IDLE;
	state_t           tgt_st = ST_IDLE;
	logic [CNT_W-1:0] pause_cnt = '0;
	logic [CNT_W-1:0] qual_cnt = '0;
	logic             chg_rly = 1'b0;
	logic             dis_rly = 1'b0;

	logic [CHG_END_W-1:0] cfg_chg_end = RST_CHARGE_END_MA;
	logic [VOLT_W-1:0]    cfg_cutoff = RST_DISCHARGE_CUTOFF_MV;
	logic                 cfg_auto = RST_AUTO_CYCLE;
	int                   cfg_max_t = int'($signed(RST_MAX_TEMP_DC));
	logic [VOLT_W-1:0]    cfg_nobatt = RST_NO_BATTERY_MV;
	logic [CNT_W-1:0]     cfg_dead = RST_DEAD_TIME_TICKS;
	logic [CNT_W-1:0]     cfg_deb = RST_DEBOUNCE_LIMIT;

	tick_res_t result_q[$];
	int        errors = 0;
	int        cyc = 0;
	bit        idle_en = 1'b1;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{REQ_NONE,      14'd0,     16'd0,      12'd0,    1'b1,
			'{1'b0, PRE_NONE, ST_IDLE, 1'b0, 1'b0}},
		'{REQ_CHARGE,    14'd16383, 16'h8000,   12'h800,  1'b1,
			'{1'b0, PRE_CHARGE, ST_CHARGE, 1'b0, 1'b1}},
		'{REQ_NONE,      14'd16383, 16'h7fff,   12'h7ff,  1'b1,
			'{1'b0, PRE_ZERO, ST_IDLE, 1'b0, 1'b0}},
		'{REQ_DISCHARGE, 14'd16383, 16'd0,      12'd500,  1'b1,
			'{1'b0, PRE_DISCHARGE, ST_DISCHARGE, 1'b1, 1'b0}},
		'{REQ_NONE,      14'd2999,  16'd0,      12'd0,    1'b0, NO_RES},
		'{REQ_NONE,      14'd0,     16'd0,      12'd0,    1'b0, NO_RES},
		'{REQ_NONE,      14'd1000,  16'hffff,   12'd0,    1'b0, NO_RES},
		'{REQ_NONE,      14'd2999,  16'd5,      12'd0,    1'b0, NO_RES},
		'{REQ_CHARGE,    14'd1999,  16'd200,    12'd0,    1'b0, NO_RES},
		'{REQ_CHARGE,    14'd2000,  16'd100,    12'd0,    1'b0, NO_RES},
		'{REQ_DISCHARGE, 14'd16383, 16'd0,      12'd0,    1'b1,
			'{1'b1, PRE_NONE, ST_DISCHARGE, 1'b0, 1'b1}},
		'{REQ_IDLE,      14'd0,     16'd0,      12'h7ff,  1'b1, DEAD_RES},
		'{REQ_CHARGE,    14'd16383, 16'h8000,   12'h800,  1'b1, DEAD_RES},
		'{REQ_DISCHARGE, 14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_NONE,      14'd5000,  16'h7fff,   12'd0,    1'b1, DEAD_RES},
		'{REQ_IDLE,      14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_NONE,      14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_CHARGE,    14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_NONE,      14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_NONE,      14'd5000,  16'd0,      12'd0,    1'b1, DEAD_RES},
		'{REQ_NONE,      14'd5000,  16'd0,      12'd0,    1'b1,
			'{1'b0, PRE_DISCHARGE, ST_DISCHARGE, 1'b0, 1'b0}},
		'{REQ_NONE,      14'd5000,  16'd0,      12'd0,    1'b0, NO_RES},
		'{REQ_IDLE,      14'd5000,  16'd0,      12'h7ff,  1'b0, NO_RES},
		'{REQ_NONE,      14'd0,     16'h8000,   12'h800,  1'b1,
			'{1'b0, PRE_NONE, ST_IDLE, 1'b0, 1'b0}},
		'{REQ_DISCHARGE, 14'd0,     16'h7fff,   12'h800,  1'b0, NO_RES}
	};

	function automatic preset_t preset_of(state_t s);
		if (s == ST_CHARGE) return PRE_CHARGE;
		if (s == ST_DISCHARGE) return PRE_DISCHARGE;
		return PRE_ZERO;
	endfunction

	function automatic bit qualify_fires();
		if (qual_cnt >= cfg_deb) begin
			qual_cnt = '0;
			return 1'b1;
		end
		qual_cnt = qual_cnt + 8'd1;
		return 1'b0;
	endfunction

	function automatic tick_res_t predict_tick(request_t req, logic [VOLT_W-1:0] v,
			logic [CURR_W-1:0] cur_b, logic [TEMP_W-1:0] t_b);
		tick_res_t r;
		int        cur;
		int        t;
		int        mag;
		preset_t   pre;
		bit        apply;
		cur = int'($signed(cur_b));
		t = int'($signed(t_b));
		mag = cur < 0 ? -cur : cur;
		pre = PRE_NONE;
		if (pause_cnt != 0) begin
			pause_cnt = pause_cnt - 8'd1;
			cmd_st = ST_IDLE;
			chg_rly = 1'b0;
			dis_rly = 1'b0;
			pre = PRE_ZERO;
			if (pause_cnt == 0) begin
				appl_st = tgt_st;
				cmd_st = appl_st;
				pre = preset_of(appl_st);
			end
		end else begin
			apply = 1'b1;
			if (req != REQ_NONE) cmd_st = state_t'(req - 2'd1);
			case (cmd_st)
				ST_CHARGE: begin
					if (mag < int'(cfg_chg_end)) begin
						if (qualify_fires()) cmd_st = ST_DISCHARGE;
					end else if (t > cfg_max_t || v < cfg_nobatt) begin
						qual_cnt = '0;
						cmd_st = ST_IDLE;
					end else begin
						qual_cnt = '0;
					end
				end
				ST_DISCHARGE: begin
					if (v < cfg_cutoff) begin
						if (qualify_fires()) cmd_st = cfg_auto ? ST_CHARGE : ST_IDLE;
					end else if (t > cfg_max_t) begin
						qual_cnt = '0;
						cmd_st = ST_IDLE;
					end else begin
						qual_cnt = '0;
					end
				end
				default: ;
			endcase
			if (cmd_st != appl_st) begin
				if ((appl_st == ST_CHARGE && cmd_st == ST_DISCHARGE) ||
					(appl_st == ST_DISCHARGE && cmd_st == ST_CHARGE)) begin
					tgt_st = cmd_st;
					pause_cnt = (cfg_dead == 0) ? 8'd1 : cfg_dead;
					apply = 1'b0;
				end else begin
					appl_st = cmd_st;
					pre = preset_of(appl_st);
				end
			end
			if (apply) begin
				cmd_st = appl_st;
				chg_rly = (appl_st == ST_CHARGE);
				dis_rly = (appl_st == ST_DISCHARGE);
			end
		end
		r.chg_relay = chg_rly;
		r.dis_relay = dis_rly;
		r.state = cmd_st;
		r.preset = pre;
		r.dead_time = (pause_cnt != 0);
		return r;
	endfunction

	function automatic int clampi(int x, int lo, int hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	task automatic check_res(tick_res_t e, logic [OUT_TDATA_W-1:0] raw);
		tick_res_t a;
		a = raw[6:0];
		if (a.chg_relay !== e.chg_relay) begin
			$display("%0t: chg_relay expected %0d actual %0d", $time, e.chg_relay,
				a.chg_relay);
			errors++;
		end
		if (a.dis_relay !== e.dis_relay) begin
			$display("%0t: dis_relay expected %0d actual %0d", $time, e.dis_relay,
				a.dis_relay);
			errors++;
		end
		if (a.state !== e.state) begin
			$display("%0t: reported_state expected %0d actual %0d", $time, e.state, a.state);
			errors++;
		end
		if (a.preset !== e.preset) begin
			$display("%0t: preset_kind expected %0d actual %0d", $time, e.preset, a.preset);
			errors++;
		end
		if (a.dead_time !== e.dead_time) begin
			$display("%0t: in_dead_time expected %0d actual %0d", $time, e.dead_time,
				a.dead_time);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
				errors++;
			end else begin
				check_res(result_q.pop_front(), m_tdata);
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= (idle_en && $urandom_range(0, 99) < 38) ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYC_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Entered and left at a falling edge.
	task automatic send_tick(request_t req, logic [VOLT_W-1:0] v, logic [CURR_W-1:0] cur,
			logic [TEMP_W-1:0] t, bit typed, tick_res_t res);
		tick_res_t pred;
		while (idle_en && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, t, cur, v, req};
		do @(posedge clk); while (!s_tready);
		pred = predict_tick(req, v, cur, t);
		result_q.push_back(typed ? res : pred);
		@(negedge clk);
	endtask

	task automatic drain_ticks();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CHARGE_END_MA:       cfg_chg_end = val[CHG_END_W-1:0];
			REG_DISCHARGE_CUTOFF_MV: cfg_cutoff = val[VOLT_W-1:0];
			REG_AUTO_CYCLE:          cfg_auto = val[0];
			REG_MAX_TEMP_DC:         cfg_max_t = int'($signed(val[TEMP_W-1:0]));
			REG_NO_BATTERY_MV:       cfg_nobatt = val[VOLT_W-1:0];
			REG_DEAD_TIME_TICKS:     cfg_dead = val[CNT_W-1:0];
			REG_DEBOUNCE_LIMIT:      cfg_deb = val[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_cfg(int ce, int co, int au, int mt, int nb, int dt, int db);
		apb_write(REG_CHARGE_END_MA, ce);
		apb_write(REG_DISCHARGE_CUTOFF_MV, co);
		apb_write(REG_AUTO_CYCLE, au);
		apb_write(REG_MAX_TEMP_DC, mt);
		apb_write(REG_NO_BATTERY_MV, nb);
		apb_write(REG_DEAD_TIME_TICKS, dt);
		apb_write(REG_DEBOUNCE_LIMIT, db);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Values cluster around the programmed thresholds so that debounce runs,
	// cutoffs and temperature trips occur often; a share is fully random.
	task automatic rand_tick();
		request_t req;
		int       vi;
		int       ci;
		int       ti;
		int       hi_v;
		req = ($urandom_range(0, 99) < 80) ? REQ_NONE : request_t'($urandom_range(1, 3));
		hi_v = int'(cfg_cutoff > cfg_nobatt ? cfg_cutoff : cfg_nobatt);
		case ($urandom_range(0, 5))
			0: vi = $urandom_range(0, 16383);
			1: vi = int'(cfg_cutoff) + int'($urandom_range(0, 60)) - 30;
			2: vi = int'(cfg_nobatt) + int'($urandom_range(0, 60)) - 30;
			default: vi = hi_v + int'($urandom_range(0, 3000));
		endcase
		case ($urandom_range(0, 3))
			0: ci = int'($urandom_range(0, 65535)) - 32768;
			1, 2: ci = clampi(int'(cfg_chg_end) + int'($urandom_range(0, 40)) - 20, 0, 32767);
			default: ci = int'($urandom_range(int'(cfg_chg_end), 32767));
		endcase
		if (ci != -32768 && $urandom_range(0, 1)) ci = -ci;
		case ($urandom_range(0, 9))
			0: ti = int'($urandom_range(0, 4095)) - 2048;
			1: ti = cfg_max_t + int'($urandom_range(0, 10)) - 5;
			default: ti = cfg_max_t - int'($urandom_range(1, 400));
		endcase
		send_tick(req, VOLT_W'(clampi(vi, 0, 16383)), CURR_W'(ci),
			TEMP_W'(clampi(ti, -2048, 2047)), 1'b0, NO_RES);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_tick(dir_tab[i].req, dir_tab[i].volt, dir_tab[i].cur, dir_tab[i].temp,
				dir_tab[i].typed, dir_tab[i].res);
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_ticks();
			case (ph)
				0: program_cfg(int'(RST_CHARGE_END_MA), int'(RST_DISCHARGE_CUTOFF_MV), 1,
					int'($signed(RST_MAX_TEMP_DC)), int'(RST_NO_BATTERY_MV),
					int'(RST_DEAD_TIME_TICKS), int'(RST_DEBOUNCE_LIMIT));
				1: program_cfg(0, 0, 0, -2048, 0, 0, 0);
				2: program_cfg(32767, 16383, 1, 2047, 16383, 255, 255);
				7: program_cfg($urandom_range(0, 32767), $urandom_range(0, 16383),
					$urandom_range(0, 1), int'($urandom_range(0, 4095)) - 2048,
					$urandom_range(0, 16383), $urandom_range(0, 255), $urandom_range(0, 255));
				default: program_cfg($urandom_range(0, 3000), $urandom_range(2500, 3500),
					$urandom_range(0, 1), int'($urandom_range(0, 1200)) - 200,
					$urandom_range(1000, 2500), $urandom_range(0, 12), $urandom_range(0, 6));
			endcase
			idle_en = (ph != 4);
			for (int n = 0; n < PHASE_TICKS; n++) rand_tick();
		end
		idle_en = 1'b1;
		drain_ticks();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
